/* rtl/ryp_pkg.sv */
// Package: widths, fixed-point constants and BT.601 coefficient table for the RGB to YPbPr converter.
package ryp_pkg;

   // Width of the components in use; bits above it are ignored.
   localparam int SAMPLE_BITS = 16;

   localparam int CH_NUM  = 3;
   localparam int COMP_W  = 16;
   localparam int COEF_W  = 21;
   localparam int PROD_W  = 38;
   localparam int ACC_W   = 38;
   localparam int MAG_W   = 36;
   localparam int DEN_W   = 36;
   localparam int NUM_W   = 52;
   localparam int QUO_W   = 16;

   localparam logic [COMP_W-1:0] SAMPLE_MASK =
      COMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   localparam logic [COMP_W-1:0] FS_RESET  = 16'd255;
   localparam logic [19:0]       COEF_ONE  = 20'd1000000;
   localparam logic [19:0]       COEF_HALF = 20'd500000;

   localparam logic signed [15:0] CHROMA_MAX = 16'sd32767;

   typedef logic signed [COEF_W-1:0] coef_type;

   // Rows: Y, Pb, Pr. Columns: R, G, B. Units of one millionth.
   localparam coef_type COEF_TAB [CH_NUM][CH_NUM] = '{
      '{ 21'sd299000,  21'sd587000,  21'sd114000 },
      '{-21'sd168736, -21'sd331264,  21'sd500000 },
      '{ 21'sd500000, -21'sd418688, -21'sd81312  }
   };

   // Channel slots in the result arrays.
   localparam int CH_LUMA = 0;
   localparam int CH_PB   = 1;
   localparam int CH_PR   = 2;

endpackage

/* rtl/rgb_to_ypbpr_converter.sv */
// Top level: pipelined BT.601 RGB to YPbPr converter with configurable full scale.
//
//  channel  ports                        direction  payload
//  -------  ---------------------------  ---------  ------------------------------------
//  request  req_valid / req_ready        in         req_red, req_green, req_blue (u16)
//  response rsp_valid / rsp_ready        out        rsp_luma (u16), rsp_blue_diff,
//                                                   rsp_red_diff (s16)
//  csr      csr_wr_en                    in         csr_wr_data (u16 full scale)
//
//  One word is accepted per clock while the pipe has room; the stages are clamp, multiply, sum,
//  numerator, sixteen restoring-divide steps (one quotient bit each) and the output
//  register. The divide steps by the full-scale denominator set the depth.
//  Synchronous reset clears all valid bits and sets full scale to 255.
//  Each stage holds only while it is full and the stage after it is blocked, so
//  bubbles close up and the request side keeps taking words behind a stalled output.
module rgb_to_ypbpr_converter
   import ryp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COMP_W-1:0]   req_red,
   input  logic [COMP_W-1:0]   req_green,
   input  logic [COMP_W-1:0]   req_blue,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_luma,
   output logic signed [15:0]  rsp_blue_diff,
   output logic signed [15:0]  rsp_red_diff,

   input  logic                csr_wr_en,
   input  logic [COMP_W-1:0]   csr_wr_data
);

   // ---------------------------------------------------------------- config
   logic [COMP_W-1:0] fs_ff;
   logic [COMP_W-1:0] fs_masked;
   logic [COMP_W-1:0] fs_eff;
   logic [DEN_W-1:0]  den_ff,  den_in;
   logic [DEN_W-1:0]  half_ff, half_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FS_RESET;
      end else if (csr_wr_en) begin
         fs_ff <= csr_wr_data;
      end
   end

   // A full scale of zero acts as one.
   assign fs_masked = fs_ff & SAMPLE_MASK;
   assign fs_eff    = (fs_masked == '0) ? COMP_W'(1) : fs_masked;
   assign den_in    = DEN_W'(fs_eff) * DEN_W'(COEF_ONE);
   assign half_in   = DEN_W'(fs_eff) * DEN_W'(COEF_HALF);

   // Denominator and its half are registered from the full-scale register; they are only
   // used from the numerator stage onwards, well after a word enters.
   always_ff @(posedge clock) begin
      if (reset) begin
         den_ff  <= DEN_W'(FS_RESET) * DEN_W'(COEF_ONE);
         half_ff <= DEN_W'(FS_RESET) * DEN_W'(COEF_HALF);
      end else begin
         den_ff  <= den_in;
         half_ff <= half_in;
      end
   end

   // ------------------------------------------------------------ load chain
   logic             ld_out;
   logic [QUO_W:0]   ld_div;
   logic             ld_sum;
   logic             ld_prod;
   logic             ld_clamp;

   logic             clamp_vld_ff;
   logic             prod_vld_ff;
   logic             sum_vld_ff;
   logic [QUO_W:0]   div_vld_ff;
   logic             rsp_vld_ff;

   assign ld_out         = !rsp_vld_ff || rsp_ready;
   assign ld_div[QUO_W]  = !div_vld_ff[QUO_W] || ld_out;
   for (genvar k = 0; k < QUO_W; k++) begin : g_ld
      assign ld_div[k] = !div_vld_ff[k] || ld_div[k+1];
   end
   assign ld_sum    = !sum_vld_ff   || ld_div[0];
   assign ld_prod   = !prod_vld_ff  || ld_sum;
   assign ld_clamp  = !clamp_vld_ff || ld_prod;
   assign req_ready = ld_clamp;

   // ----------------------------------------------------------- clamp stage
   logic [COMP_W-1:0] req_comp [CH_NUM];
   logic [COMP_W-1:0] comp_ff  [CH_NUM];
   logic [COMP_W-1:0] comp_in  [CH_NUM];

   assign req_comp[0] = req_red   & SAMPLE_MASK;
   assign req_comp[1] = req_green & SAMPLE_MASK;
   assign req_comp[2] = req_blue  & SAMPLE_MASK;

   // Clamp any component above full scale.
   always_comb begin
      for (int c = 0; c < CH_NUM; c++) begin
         comp_in[c] = (req_comp[c] > fs_eff) ? fs_eff : req_comp[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_vld_ff <= 1'b0;
      end else if (ld_clamp) begin
         clamp_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_clamp) begin
         comp_ff <= comp_in;
      end
   end

   // -------------------------------------------------------- multiply stage
   logic signed [PROD_W-1:0] prod_ff [CH_NUM][CH_NUM];
   logic signed [PROD_W-1:0] prod_in [CH_NUM][CH_NUM];

   always_comb begin
      for (int k = 0; k < CH_NUM; k++) begin
         for (int c = 0; c < CH_NUM; c++) begin
            prod_in[k][c] = PROD_W'($signed({1'b0, comp_ff[c]})) *
                            PROD_W'(COEF_TAB[k][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (ld_prod) begin
         prod_vld_ff <= clamp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_prod) begin
         prod_ff <= prod_in;
      end
   end

   // ------------------------------------------------------------- sum stage
   logic signed [ACC_W-1:0] acc_ff [CH_NUM];
   logic signed [ACC_W-1:0] acc_in [CH_NUM];

   always_comb begin
      for (int k = 0; k < CH_NUM; k++) begin
         acc_in[k] = ACC_W'(prod_ff[k][0]) + ACC_W'(prod_ff[k][1]) +
                     ACC_W'(prod_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else if (ld_sum) begin
         sum_vld_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_sum) begin
         acc_ff <= acc_in;
      end
   end

   // ------------------------------------------------------- numerator stage
   // Numerator is |acc| * 65535 + den / 2, so the floor of the quotient is the
   // magnitude rounded half away from zero.
   logic [NUM_W-1:0]  div_rem_ff [QUO_W+1][CH_NUM];
   logic [QUO_W-1:0]  div_quo_ff [QUO_W+1][CH_NUM];
   logic [CH_NUM-1:0] div_neg_ff [QUO_W+1];

   logic [MAG_W-1:0]  mag      [CH_NUM];
   logic [NUM_W-1:0]  num_in   [CH_NUM];
   logic [CH_NUM-1:0] neg_in;

   always_comb begin
      for (int k = 0; k < CH_NUM; k++) begin
         neg_in[k] = acc_ff[k][ACC_W-1];
         mag[k]    = neg_in[k] ? MAG_W'(-acc_ff[k]) : MAG_W'(acc_ff[k]);
         num_in[k] = (NUM_W'(mag[k]) << 16) - NUM_W'(mag[k]) + NUM_W'(half_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (ld_div[0]) begin
         div_vld_ff[0] <= sum_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_div[0]) begin
         div_neg_ff[0] <= neg_in;
         for (int k = 0; k < CH_NUM; k++) begin
            div_rem_ff[0][k] <= num_in[k];
            div_quo_ff[0][k] <= '0;
         end
      end
   end

   // --------------------------------------------------------- divide stages
   // Step k tries den << (QUO_W-k) and settles one quotient bit.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_div
      logic [NUM_W-1:0] den_sh;
      logic [NUM_W:0]   trial [CH_NUM];

      assign den_sh = NUM_W'(den_ff) << (QUO_W - k);

      always_comb begin
         for (int c = 0; c < CH_NUM; c++) begin
            trial[c] = {1'b0, div_rem_ff[k-1][c]} - {1'b0, den_sh};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k] <= 1'b0;
         end else if (ld_div[k]) begin
            div_vld_ff[k] <= div_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ld_div[k]) begin
            div_neg_ff[k] <= div_neg_ff[k-1];
            for (int c = 0; c < CH_NUM; c++) begin
               if (!trial[c][NUM_W]) begin
                  div_rem_ff[k][c] <= trial[c][NUM_W-1:0];
                  div_quo_ff[k][c] <= div_quo_ff[k-1][c] |
                                      (QUO_W'(1) << (QUO_W - k));
               end else begin
                  div_rem_ff[k][c] <= div_rem_ff[k-1][c];
                  div_quo_ff[k][c] <= div_quo_ff[k-1][c];
               end
            end
         end
      end
   end

   // ---------------------------------------------------------- output stage
   logic [QUO_W-1:0]   q_luma, q_pb, q_pr;
   logic [15:0]        luma_ff,  luma_in;
   logic signed [15:0] pb_ff,    pb_in;
   logic signed [15:0] pr_ff,    pr_in;

   assign q_luma = div_quo_ff[QUO_W][CH_LUMA];
   assign q_pb   = div_quo_ff[QUO_W][CH_PB];
   assign q_pr   = div_quo_ff[QUO_W][CH_PR];

   // Apply sign, drop negative luma, saturate the colour differences at +32767.
   always_comb begin
      luma_in = div_neg_ff[QUO_W][CH_LUMA] ? '0 : 16'(q_luma);

      if (div_neg_ff[QUO_W][CH_PB]) begin
         pb_in = 16'(-$signed({1'b0, q_pb}));
      end else if (q_pb > QUO_W'(CHROMA_MAX)) begin
         pb_in = CHROMA_MAX;
      end else begin
         pb_in = 16'(q_pb);
      end

      if (div_neg_ff[QUO_W][CH_PR]) begin
         pr_in = 16'(-$signed({1'b0, q_pr}));
      end else if (q_pr > QUO_W'(CHROMA_MAX)) begin
         pr_in = CHROMA_MAX;
      end else begin
         pr_in = 16'(q_pr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (ld_out) begin
         rsp_vld_ff <= div_vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_out) begin
         luma_ff <= luma_in;
         pb_ff   <= pb_in;
         pr_ff   <= pr_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_luma      = luma_ff;
   assign rsp_blue_diff = pb_ff;
   assign rsp_red_diff  = pr_ff;

   // ------------------------------------------------------------ assertions
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> clamp_vld_ff)
      else $error("accepted word missing from clamp stage");

   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      div_vld_ff[QUO_W] |-> (div_rem_ff[QUO_W][CH_LUMA] < NUM_W'(den_ff)) &&
                            (div_rem_ff[QUO_W][CH_PB]   < NUM_W'(den_ff)) &&
                            (div_rem_ff[QUO_W][CH_PR]   < NUM_W'(den_ff)))
      else $error("divider remainder not below denominator");

   a_den_nonzero : assert property (@(posedge clock) disable iff (reset)
      den_ff != '0)
      else $error("denominator is zero");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && (&div_vld_ff) && sum_vld_ff && prod_vld_ff &&
       clamp_vld_ff) |-> !req_ready)
      else $error("request taken while every stage is full and stalled");

endmodule

/* dv/rgb_to_ypbpr_converter_tb.sv */
// Self-checking testbench for the BT.601 RGB to YPbPr converter.
`timescale 1ns / 1ps

module rgb_to_ypbpr_converter_tb;
   import ryp_pkg::*;

   localparam int    ROW_COUNT        = 17;
   localparam int    PLAN_COUNT       = 9;
   localparam int    RANDOM_PER_PHASE = 158;
   localparam int    WATCHDOG_LIMIT   = 2000;
   localparam int    SETTLE_CYCLES    = 30;
   localparam int    LONG_STALL       = 150;
   localparam longint MILLION         = 1000000;
   localparam longint OUT_SCALE       = 65535;

   // BT.601 matrix in millionths; rows Y, Pb, Pr and columns R, G, B.
   localparam longint BT601 [3][3] = '{
      '{ 299000,  587000,  114000},
      '{-168736, -331264,  500000},
      '{ 500000, -418688,  -81312}
   };

   typedef struct packed {
      logic [15:0]        luma;
      logic signed [15:0] blue_diff;
      logic signed [15:0] red_diff;
   } ypbpr_type;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      bit          typed;
      ypbpr_type   want;
   } pixel_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [COMP_W-1:0]  req_red = '0;
   logic [COMP_W-1:0]  req_green = '0;
   logic [COMP_W-1:0]  req_blue = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_luma;
   logic signed [15:0] rsp_blue_diff;
   logic signed [15:0] rsp_red_diff;
   logic               csr_wr_en = 1'b0;
   logic [COMP_W-1:0]  csr_wr_data = '0;

   ypbpr_type     pending_ypbpr [$];
   logic [15:0]   full_scale_copy = FS_RESET;
   bit            no_idle = 1'b0;
   int            fault_count = 0;
   int            quiet_cycles = 0;
   pixel_row_type directed_rows [ROW_COUNT];

   rgb_to_ypbpr_converter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_luma      (rsp_luma),
      .rsp_blue_diff (rsp_blue_diff),
      .rsp_red_diff  (rsp_red_diff),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // Divide and round to nearest, ties away from zero; divisor is always positive.
   function automatic longint div_round_away(longint num, longint den);
      longint mag;
      longint quo;
      mag = (num < 0) ? -num : num;
      quo = (mag + den / 2) / den;
      return (num < 0) ? -quo : quo;
   endfunction

   // Expected Y/Pb/Pr for one pixel under a given full scale, exact rational
   // arithmetic with a single rounding at the end.
   function automatic ypbpr_type convert_pixel(logic [15:0] red, logic [15:0] green,
                                               logic [15:0] blue, logic [15:0] scale);
      longint    fs;
      longint    den;
      longint    acc;
      longint    comp [3];
      longint    chan [3];
      ypbpr_type res;
      fs = scale & SAMPLE_MASK;
      if (fs == 0) begin
         fs = 1;
      end
      comp[0] = red & SAMPLE_MASK;
      comp[1] = green & SAMPLE_MASK;
      comp[2] = blue & SAMPLE_MASK;
      foreach (comp[c]) begin
         if (comp[c] > fs) begin
            comp[c] = fs;
         end
      end
      den = fs * MILLION;
      for (int k = 0; k < 3; k++) begin
         acc = 0;
         for (int c = 0; c < 3; c++) begin
            acc += BT601[k][c] * comp[c];
         end
         chan[k] = div_round_away(acc * OUT_SCALE, den);
      end
      if (chan[CH_LUMA] < 0)          chan[CH_LUMA] = 0;
      if (chan[CH_LUMA] > 65535)      chan[CH_LUMA] = 65535;
      if (chan[CH_PB] < -32768)       chan[CH_PB] = -32768;
      if (chan[CH_PB] > 32767)        chan[CH_PB] = 32767;
      if (chan[CH_PR] < -32768)       chan[CH_PR] = -32768;
      if (chan[CH_PR] > 32767)        chan[CH_PR] = 32767;
      res.luma      = chan[CH_LUMA][15:0];
      res.blue_diff = chan[CH_PB][15:0];
      res.red_diff  = chan[CH_PR][15:0];
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      fault_count++;
   endtask

   // Draw a component: mostly inside the full scale, with some extremes, words
   // just above it and unconstrained 16-bit values so every bit toggles.
   function automatic logic [15:0] pick_component(logic [15:0] scale);
      logic [15:0] eff;
      eff = scale & SAMPLE_MASK;
      if (eff == 0) begin
         eff = 1;
      end
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return eff;
         2:       return 16'hFFFF;
         3:       return (eff == 16'hFFFF) ? eff : eff + 16'd1;
         4, 5:    return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, eff));
      endcase
   endfunction

   // Offer one pixel and hold it until taken; valid is only dropped when a gap
   // follows, so back-to-back words keep valid high without a glitch.
   task automatic send_pixel(logic [15:0] red, logic [15:0] green, logic [15:0] blue,
                             bit typed, ypbpr_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      do @(posedge clock); while (!req_ready);
      pending_ypbpr.push_back(typed ? want : convert_pixel(red, green, blue, full_scale_copy));
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_ypbpr.size() != 0) @(posedge clock);
   endtask

   task automatic write_full_scale(logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      full_scale_copy  = value;
   endtask

   task automatic send_random_batch();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         send_pixel(pick_component(full_scale_copy), pick_component(full_scale_copy),
                    pick_component(full_scale_copy), 1'b0, '0);
      end
   endtask

   // Check every taken result word against the oldest expectation, and keep the
   // watchdog: it counts cycles in which neither side moves a word.
   always @(posedge clock) begin
      ypbpr_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ypbpr.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected: %0d %0d %0d",
                                      rsp_luma, rsp_blue_diff, rsp_red_diff));
         end else begin
            want = pending_ypbpr.pop_front();
            if (rsp_luma !== want.luma)
               report_mismatch($sformatf("luma got %0d want %0d", rsp_luma, want.luma));
            if (rsp_blue_diff !== want.blue_diff)
               report_mismatch($sformatf("blue_diff got %0d want %0d",
                                         rsp_blue_diff, want.blue_diff));
            if (rsp_red_diff !== want.red_diff)
               report_mismatch($sformatf("red_diff got %0d want %0d",
                                         rsp_red_diff, want.red_diff));
         end
      end
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("rgb_to_ypbpr_converter_tb: FAIL");
         $finish;
      end
   end

   // Receiver: random back-pressure per word, whole phases without it, and two
   // long hold-offs so the pipe fills and the request side stalls.
   initial begin
      int gap;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 200 || taken == 1000) begin
            gap = LONG_STALL;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         taken++;
      end
   end

   initial begin
      logic [15:0] fs_plan [PLAN_COUNT];

      // Directed words at the reset full scale of 255. Primaries, black, white
      // and clamped words have values worked out by hand; the rest go through
      // the predictor. Pure blue and pure red hit the colour-difference ceiling.
      directed_rows = '{
         '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0,     16'sd0,      16'sd0}},
         '{16'd255,   16'd255,   16'd255,   1'b1, '{16'd65535, 16'sd0,      16'sd0}},
         '{16'd255,   16'd0,     16'd0,     1'b1, '{16'd19595, -16'sd11058, 16'sd32767}},
         '{16'd0,     16'd255,   16'd0,     1'b1, '{16'd38469, -16'sd21709, -16'sd27439}},
         '{16'd0,     16'd0,     16'd255,   1'b1, '{16'd7471,  16'sd32767,  -16'sd5329}},
         '{16'd65535, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'sd0,      16'sd0}},
         '{16'd256,   16'd0,     16'd0,     1'b1, '{16'd19595, -16'sd11058, 16'sd32767}},
         '{16'd0,     16'd256,   16'd0,     1'b1, '{16'd38469, -16'sd21709, -16'sd27439}},
         '{16'd0,     16'd0,     16'd65535, 1'b1, '{16'd7471,  16'sd32767,  -16'sd5329}},
         '{16'd255,   16'd255,   16'd0,     1'b0, '0},
         '{16'd0,     16'd255,   16'd255,   1'b0, '0},
         '{16'd255,   16'd0,     16'd255,   1'b0, '0},
         '{16'd128,   16'd128,   16'd128,   1'b0, '0},
         '{16'd1,     16'd0,     16'd0,     1'b0, '0},
         '{16'd254,   16'd1,     16'd200,   1'b0, '0},
         '{16'hFF00,  16'h00FF,  16'h8000,  1'b0, '0},
         '{16'hAAAA,  16'h5555,  16'h0001,  1'b0, '0}
      };

      // Full-scale settings per phase: extremes, zero (treated as one), small
      // and mid values, two random ones, then 255 written back explicitly.
      fs_plan = '{16'd65535, 16'd1, 16'd0, 16'd2, 16'd1023, 16'd32768,
                  16'd0, 16'd0, 16'd255};
      fs_plan[6] = 16'($urandom_range(3, 65534));
      fs_plan[7] = 16'($urandom_range(3, 300));

      // Hold reset, then release it for good.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                    directed_rows[i].typed, directed_rows[i].want);
      end
      send_random_batch();

      for (int phase = 0; phase < PLAN_COUNT; phase++) begin
         drain_pipe();
         // The register only changes with the pipe empty.
         write_full_scale(fs_plan[phase]);
         no_idle = (phase % 3 == 1);
         send_random_batch();
      end

      // Wait out the last words, then allow the pipe latency for strays.
      drain_pipe();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("rgb_to_ypbpr_converter_tb: PASS");
      end else begin
         $display("rgb_to_ypbpr_converter_tb: FAIL");
      end
      $finish;
   end

endmodule

/* rgb_to_ypbpr_converter.f */
rtl/ryp_pkg.sv
rtl/rgb_to_ypbpr_converter.sv
dv/rgb_to_ypbpr_converter_tb.sv
